// ===== rtl/irsm_pkg.sv =====
package irsm_pkg;

	localparam int DefMaxBeams = 64;
	localparam int CordicSteps = 16;
	localparam logic [15:0] MinCone = 16'd455;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [1:0] CLS_UNKNOWN  = 2'd0;
	localparam logic [1:0] CLS_FREE     = 2'd1;
	localparam logic [1:0] CLS_OCCUPIED = 2'd2;

	localparam logic [2:0] REG_MAX_RANGE = 3'd0;
	localparam logic [2:0] REG_HALF_THICK = 3'd1;
	localparam logic [2:0] REG_FOV = 3'd2;
	localparam logic [2:0] REG_BEAM_COUNT = 3'd3;
	localparam logic [2:0] REG_CONE = 3'd4;
	localparam logic [2:0] REG_FREE_LO = 3'd5;
	localparam logic [2:0] REG_OCC_LO = 3'd6;
	localparam logic [2:0] REG_UNK_LO = 3'd7;

	typedef struct packed {
		logic signed [16:0] dx;
		logic signed [16:0] dy;
		logic [15:0] heading;
	} query_t;

	typedef struct packed {
		logic [15:0] max_range;
		logic [15:0] half_thick;
		logic [15:0] fov;
		logic [6:0]  beam_count;
		logic [15:0] cone;
		logic [10:0] free_lo;
		logic [10:0] occ_lo;
		logic [10:0] unk_lo;
	} cfg_t;

	function automatic logic [31:0] atan_entry(input logic [3:0] i);
		logic [31:0] v;
		begin
			unique case (i)
				4'd0: v = 32'h20000000;
				4'd1: v = 32'h12E4051D;
				4'd2: v = 32'h09FB385B;
				4'd3: v = 32'h051111D4;
				4'd4: v = 32'h028B0D43;
				4'd5: v = 32'h0145D7E1;
				4'd6: v = 32'h00A2F61E;
				4'd7: v = 32'h00517C55;
				4'd8: v = 32'h0028BE53;
				4'd9: v = 32'h00145F2E;
				4'd10: v = 32'h000A2F98;
				4'd11: v = 32'h000517CC;
				4'd12: v = 32'h00028BE6;
				4'd13: v = 32'h000145F3;
				4'd14: v = 32'h0000A2F9;
				default: v = 32'h0000517C;
			endcase
			return v;
		end
	endfunction

endpackage

// ===== rtl/irsm_front.sv =====
module irsm_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   valid,
	output logic                   stall,
	input  logic signed [15:0]     point_x,
	input  logic signed [15:0]     point_y,
	input  logic signed [15:0]     robot_x,
	input  logic signed [15:0]     robot_y,
	input  logic [15:0]            robot_heading,
	input  logic                   is_query,
	output logic                   q_valid,
	input  logic                   q_ready,
	output irsm_pkg::query_t       q_data
);
	// two-entry queue holding query operands for the back end
	irsm_pkg::query_t mem_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign stall = (cnt_q == 2'd2);
	assign push = valid && !stall && is_query;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q].dx <= 17'(point_x) - 17'(robot_x);
			mem_q[wr_q].dy <= 17'(point_y) - 17'(robot_y);
			mem_q[wr_q].heading <= robot_heading;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ===== rtl/irsm_back.sv =====
module irsm_back #(
	parameter int MAX_BEAMS = irsm_pkg::DefMaxBeams
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	output logic                   q_ready,
	input  irsm_pkg::query_t       q_data,
	input  irsm_pkg::cfg_t         cfg,
	input  logic                   ld_en,
	input  logic [5:0]             ld_idx,
	input  logic [15:0]            ld_range,
	input  logic [15:0]            ld_bearing,
	output logic                   valid,
	input  logic                   stall,
	output logic signed [10:0]     log_odds,
	output logic [1:0]             cell_class
);
	localparam int IW = (MAX_BEAMS > 1) ? $clog2(MAX_BEAMS) : 1;
	localparam int CW = $clog2(MAX_BEAMS + 1);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SQ   = 4'd1;
	localparam logic [3:0] ST_CORD = 4'd2;
	localparam logic [3:0] ST_PHI  = 4'd3;
	localparam logic [3:0] ST_SEL  = 4'd4;
	localparam logic [3:0] ST_DIV  = 4'd5;
	localparam logic [3:0] ST_SRCH = 4'd6;
	localparam logic [3:0] ST_RDK  = 4'd7;
	localparam logic [3:0] ST_WAIT = 4'd8;
	localparam logic [3:0] ST_T1   = 4'd9;
	localparam logic [3:0] ST_T2   = 4'd10;
	localparam logic [3:0] ST_T3   = 4'd11;
	localparam logic [3:0] ST_OUT  = 4'd12;

	logic [15:0] rmem [MAX_BEAMS];
	logic [15:0] bmem [MAX_BEAMS];
	logic [15:0] rd_range_q, rd_bear_q;
	logic [IW-1:0] rd_addr;

	logic [3:0] st_q;
	logic signed [16:0] dx_q, dy_q;
	logic [15:0] head_q;
	logic [33:0] r2_q;
	logic [33:0] dxx_q;
	logic [33:0] r2sum_q;
	logic signed [35:0] cx_q, cy_q;
	logic [31:0] cz_q;
	logic [4:0] it_q;
	logic signed [15:0] phi_q;
	logic [CW-1:0] n_q;
	logic [IW-1:0] k_q;
	logic [CW-1:0] i_q;
	logic [16:0] best_q;
	logic bvalid_q;
	// restoring division of num by den, unsigned
	logic [23:0] num_q;
	logic [17:0] den_q;
	logic [23:0] rem_q;
	logic [1:0] ph_q;
	logic [16:0] lim_q;
	logic [33:0] prod_q;
	logic out_v_q;
	logic signed [10:0] lo_q;
	logic [1:0] cls_q;
	logic occ_ok_q;

	logic signed [35:0] sx, sy;
	logic [16:0] dabs;
	logic signed [17:0] dsig;
	logic [16:0] mh;
	logic [16:0] rh;
	logic [24:0] trial;
	logic [15:0] cone_eff;
	logic [CW-1:0] n_eff;

	always_ff @(posedge clk) begin
		if (ld_en && (32'(ld_idx) < MAX_BEAMS)) begin
			rmem[IW'(ld_idx)] <= ld_range;
			bmem[IW'(ld_idx)] <= ld_bearing;
		end
		rd_range_q <= rmem[rd_addr];
		rd_bear_q <= bmem[rd_addr];
	end

	assign rd_addr = (st_q == ST_SRCH) ? IW'(i_q) : k_q;
	assign sx = cx_q >>> it_q[3:0];
	assign sy = cy_q >>> it_q[3:0];
	assign dsig = 18'(phi_q) - 18'($signed(rd_bear_q));
	assign dabs = dsig[17] ? 17'(-dsig) : 17'(dsig);
	assign mh = 17'(cfg.max_range) + 17'(cfg.half_thick);
	assign rh = 17'(rd_range_q) + 17'(cfg.half_thick);
	assign trial = {rem_q, num_q[23]} - 25'(den_q);
	assign cone_eff = (cfg.cone > irsm_pkg::MinCone) ? cfg.cone : irsm_pkg::MinCone;
	always_comb begin
		if (cfg.beam_count == 7'd0) n_eff = CW'(1);
		else if (32'(cfg.beam_count) > MAX_BEAMS) n_eff = CW'(MAX_BEAMS);
		else n_eff = CW'(cfg.beam_count);
	end

	// take a new query only once the previous result has been transferred
	assign q_ready = (st_q == ST_IDLE) && !out_v_q;
	assign valid = out_v_q;
	assign log_odds = lo_q;
	assign cell_class = cls_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			out_v_q <= 1'b0;
		end else begin
			if (st_q == ST_OUT) out_v_q <= 1'b1;
			else if (out_v_q && !stall) out_v_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (q_valid && q_ready) st_q <= ST_SQ;
				ST_SQ: if (ph_q == 2'd1) st_q <= (dxx_q + r2_q > prod_q) ? ST_OUT : ST_CORD;
				ST_CORD: if (it_q == 5'(irsm_pkg::CordicSteps)) st_q <= ST_PHI;
				ST_PHI: st_q <= ST_SEL;
				ST_SEL: begin
					if (cfg.cone != 16'd0) st_q <= ST_SRCH;
					else if ((19'(phi_q) <<< 1) < -$signed(19'(cfg.fov))) st_q <= ST_RDK;
					else if ((19'(phi_q) <<< 1) > $signed(19'(cfg.fov))) st_q <= ST_RDK;
					else if (cfg.fov == 16'd0) st_q <= ST_RDK;
					else st_q <= ST_DIV;
				end
				ST_DIV: if (it_q == 5'd24) st_q <= ST_RDK;
				ST_SRCH: if (bvalid_q && i_q == n_q) st_q <= ST_RDK;
				ST_RDK: st_q <= ST_WAIT;
				ST_WAIT: st_q <= ST_T1;
				ST_T1: st_q <= ST_T2;
				ST_T2: st_q <= ST_T3;
				ST_T3: st_q <= ST_OUT;
				ST_OUT: st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				dx_q <= q_data.dx;
				dy_q <= q_data.dy;
				head_q <= q_data.heading;
				ph_q <= 2'd0;
				lo_q <= lo_q;
			end
			ST_SQ: begin
				// dx^2, then + dy^2 and threshold squared
				if (ph_q == 2'd0) begin
					dxx_q <= 34'(dx_q) * 34'(dx_q);
					prod_q <= 34'(mh) * 34'(mh);
					ph_q <= 2'd1;
				end
				r2_q <= 34'(dy_q) * 34'(dy_q);
				if (ph_q == 2'd1) begin
					lo_q <= $signed(cfg.unk_lo);
					cls_q <= irsm_pkg::CLS_UNKNOWN;
				end
				it_q <= 5'd0;
				if (dx_q[16]) begin
					cx_q <= -(36'(dx_q) <<< 16);
					cy_q <= -(36'(dy_q) <<< 16);
					cz_q <= 32'h80000000;
				end else begin
					cx_q <= 36'(dx_q) <<< 16;
					cy_q <= 36'(dy_q) <<< 16;
					cz_q <= 32'd0;
				end
			end
			ST_CORD: begin
				if (it_q != 5'(irsm_pkg::CordicSteps)) begin
					if (!cy_q[35]) begin
						cx_q <= cx_q + sy;
						cy_q <= cy_q - sx;
						cz_q <= cz_q + irsm_pkg::atan_entry(it_q[3:0]);
					end else begin
						cx_q <= cx_q - sy;
						cy_q <= cy_q + sx;
						cz_q <= cz_q - irsm_pkg::atan_entry(it_q[3:0]);
					end
					it_q <= it_q + 5'd1;
				end
			end
			ST_PHI: begin
				if (dx_q == 17'sd0 && dy_q == 17'sd0) phi_q <= $signed(16'd0 - head_q);
				else phi_q <= $signed(16'((cz_q + 32'h8000) >> 16) - head_q);
				n_q <= n_eff;
			end
			ST_SEL: begin
				i_q <= '0;
				it_q <= 5'd0;
				bvalid_q <= 1'b0;
				best_q <= '1;
				k_q <= ((19'(phi_q) <<< 1) > $signed(19'(cfg.fov))) ?
					IW'(n_q - CW'(1)) : '0;
				num_q <= 24'(18'((19'(phi_q) <<< 1) + 19'(cfg.fov))) * 24'(n_q);
				den_q <= {1'b0, cfg.fov, 1'b0};
				rem_q <= '0;
			end
			ST_DIV: begin
				if (it_q != 5'd24) begin
					if (!trial[24]) rem_q <= trial[23:0];
					else rem_q <= {rem_q[22:0], num_q[23]};
					num_q <= {num_q[22:0], !trial[24]};
					it_q <= it_q + 5'd1;
				end else begin
					if (num_q >= 24'(n_q)) k_q <= IW'(n_q - CW'(1));
					else k_q <= IW'(num_q);
				end
			end
			ST_SRCH: begin
				// memory read of i_q lands in the next cycle
				if (bvalid_q) begin
					if (dabs < best_q) begin
						best_q <= dabs;
						k_q <= IW'(i_q - CW'(1));
					end
				end
				if (i_q != n_q) begin
					i_q <= i_q + CW'(1);
					bvalid_q <= 1'b1;
				end
			end
			ST_RDK: ;
			ST_WAIT: ;
			ST_T1: begin
				lim_q <= (rh < 17'(cfg.max_range)) ? rh : 17'(cfg.max_range);
				occ_ok_q <= (18'(dabs) << 1) <= 18'(cone_eff);
			end
			ST_T2: begin
				prod_q <= 34'(lim_q) * 34'(lim_q);
				lim_q <= (rd_range_q > cfg.half_thick) ? 17'(rd_range_q - cfg.half_thick) : '0;
				r2_q <= 34'(rh) * 34'(rh);
			end
			ST_T3: begin
				if (r2sum_q > prod_q || !occ_ok_q) begin
					lo_q <= $signed(cfg.unk_lo);
					cls_q <= irsm_pkg::CLS_UNKNOWN;
				end else if (rd_range_q < cfg.max_range && r2sum_q < r2_q &&
						(rd_range_q < cfg.half_thick ||
						r2sum_q > 34'(lim_q) * 34'(lim_q))) begin
					lo_q <= $signed(cfg.occ_lo);
					cls_q <= irsm_pkg::CLS_OCCUPIED;
				end else begin
					lo_q <= $signed(cfg.free_lo);
					cls_q <= irsm_pkg::CLS_FREE;
				end
			end
			ST_OUT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_SQ && ph_q == 2'd1) r2sum_q <= dxx_q + r2_q;
	end
endmodule

// ===== rtl/inverse_range_sensor_model.sv =====
// A point beyond max range plus half thickness gets an unknown result without a beam
// lookup; else the beam is picked directly, by the 24-step laser index division, or by
// the sonar search over the beams in use.
// One query is worked at a time; a two-entry queue holds further queries, and a load
// stalls until no query is queued, in progress or waiting at the output.
// Reset (arst_n low, asynchronous) clears control state and sets registers.
module inverse_range_sensor_model #(
	parameter int MAX_BEAMS = irsm_pkg::DefMaxBeams
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [5:0]         beam_index,
	input  logic [15:0]        beam_range,
	input  logic signed [15:0] beam_bearing,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	input  logic signed [15:0] robot_x,
	input  logic signed [15:0] robot_y,
	input  logic [15:0]        robot_heading,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [10:0] log_odds,
	output logic [1:0]         cell_class,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	irsm_pkg::cfg_t cfg_q;
	irsm_pkg::query_t q_data;
	logic q_valid, q_ready;
	logic front_stall;

	assign cfg_ready = 1'b1;

	// hold a load while any query is queued or in progress so table writes keep order
	assign in_stall = front_stall || (op == irsm_pkg::OP_LOAD && (q_valid || !q_ready));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_range <= 16'd0;
			cfg_q.half_thick <= 16'd600;
			cfg_q.fov <= 16'd0;
			cfg_q.beam_count <= 7'd1;
			cfg_q.cone <= 16'd0;
			cfg_q.free_lo <= 11'h7E6;
			cfg_q.occ_lo <= 11'd102;
			cfg_q.unk_lo <= 11'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				irsm_pkg::REG_MAX_RANGE: cfg_q.max_range <= cfg_data;
				irsm_pkg::REG_HALF_THICK: cfg_q.half_thick <= cfg_data;
				irsm_pkg::REG_FOV: cfg_q.fov <= cfg_data;
				irsm_pkg::REG_BEAM_COUNT: cfg_q.beam_count <= cfg_data[6:0];
				irsm_pkg::REG_CONE: cfg_q.cone <= cfg_data;
				irsm_pkg::REG_FREE_LO: cfg_q.free_lo <= cfg_data[10:0];
				irsm_pkg::REG_OCC_LO: cfg_q.occ_lo <= cfg_data[10:0];
				default: cfg_q.unk_lo <= cfg_data[10:0];
			endcase
		end
	end

	irsm_front u_front (
		.clk, .arst_n,
		.valid(in_valid), .stall(front_stall),
		.point_x, .point_y, .robot_x, .robot_y, .robot_heading,
		.is_query(op == irsm_pkg::OP_QUERY),
		.q_valid, .q_ready, .q_data
	);

	irsm_back #(.MAX_BEAMS(MAX_BEAMS)) u_back (
		.clk, .arst_n,
		.q_valid, .q_ready, .q_data,
		.cfg(cfg_q),
		.ld_en(in_valid && !in_stall && op == irsm_pkg::OP_LOAD),
		.ld_idx(beam_index), .ld_range(beam_range), .ld_bearing(beam_bearing),
		.valid(out_valid), .stall(out_stall), .log_odds, .cell_class
	);

`ifndef SYNTH
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(log_odds))
		else $error("result dropped while stalled");
	a_class: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cell_class != 2'd3)
		else $error("bad class");
`endif
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;

	typedef struct {
		logic               op;
		logic [5:0]         beam_index;
		logic [15:0]        beam_range;
		logic signed [15:0] beam_bearing;
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic signed [15:0] robot_x;
		logic signed [15:0] robot_y;
		logic [15:0]        robot_heading;
	} sensor_item_t;

	typedef struct {
		logic signed [10:0] log_odds;
		logic [1:0]         cell_class;
	} cell_update_t;

	class odds_board;
		logic [15:0] max_range = 16'd0;
		logic [15:0] half_thick = 16'd600;
		logic [15:0] fov = 16'd0;
		logic [6:0]  beam_count = 7'd1;
		logic [15:0] cone = 16'd0;
		logic signed [10:0] free_lo = -11'sd26;
		logic signed [10:0] occ_lo = 11'sd102;
		logic signed [10:0] unk_lo = 11'sd0;
		logic [15:0] range_tab [64];
		logic signed [15:0] bearing_tab [64];
		cell_update_t updates_due [$];
		int errors = 0;

		function void set_reg(logic [2:0] idx, logic [15:0] data);
			case (idx)
				irsm_pkg::REG_MAX_RANGE:  max_range = data;
				irsm_pkg::REG_HALF_THICK: half_thick = data;
				irsm_pkg::REG_FOV:        fov = data;
				irsm_pkg::REG_BEAM_COUNT: beam_count = data[6:0];
				irsm_pkg::REG_CONE:       cone = data;
				irsm_pkg::REG_FREE_LO:    free_lo = data[10:0];
				irsm_pkg::REG_OCC_LO:     occ_lo = data[10:0];
				default:                  unk_lo = data[10:0];
			endcase
		endfunction

		function logic [15:0] bearing_of(longint dx, longint dy);
			logic [31:0] atan_bau [16];
			logic [31:0] z;
			longint x, y, nx;
			atan_bau = '{32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
				32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
				32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
				32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C};
			if (dx == 0 && dy == 0)
				return 16'd0;
			x = dx * 65536;
			y = dy * 65536;
			z = 32'd0;
			// turn the left half plane by a half turn first
			if (x < 0) begin
				x = -x;
				y = -y;
				z = 32'h80000000;
			end
			for (int i = 0; i < 16; i++) begin
				if (y >= 0) begin
					nx = x + (y >>> i);
					y = y - (x >>> i);
					z = z + atan_bau[i];
				end else begin
					nx = x - (y >>> i);
					y = y + (x >>> i);
					z = z - atan_bau[i];
				end
				x = nx;
			end
			z = z + 32'h8000;
			return z[31:16];
		endfunction

		function void note_input(sensor_item_t it);
			longint dx, dy, r2, m, h, phi, n, k, q, d, best, rng, lim, lo, f, cone_eff;
			logic [15:0] rel;
			cell_update_t u;
			if (it.op == irsm_pkg::OP_LOAD) begin
				range_tab[it.beam_index] = it.beam_range;
				bearing_tab[it.beam_index] = it.beam_bearing;
				return;
			end
			dx = longint'(it.point_x) - longint'(it.robot_x);
			dy = longint'(it.point_y) - longint'(it.robot_y);
			r2 = dx * dx + dy * dy;
			m = max_range;
			h = half_thick;
			u.log_odds = unk_lo;
			u.cell_class = irsm_pkg::CLS_UNKNOWN;
			if (r2 > (m + h) * (m + h)) begin
				updates_due.push_back(u);
				return;
			end
			rel = bearing_of(dx, dy) - it.robot_heading;
			phi = longint'($signed(rel));
			cone_eff = (cone > irsm_pkg::MinCone) ? cone : irsm_pkg::MinCone;
			n = beam_count;
			if (n < 1) n = 1;
			if (n > 64) n = 64;
			k = 0;
			if (cone == 16'd0) begin
				f = fov;
				if (2 * phi < -f) k = 0;
				else if (2 * phi > f) k = n - 1;
				else if (f == 0) k = 0;
				else begin
					q = (2 * phi + f) * n / (2 * f);
					k = (q > n - 1) ? n - 1 : q;
				end
			end else begin
				best = 64'sh7FFFFFFFFFFFFFFF;
				for (int i = 0; i < n; i++) begin
					d = phi - longint'(bearing_tab[i]);
					if (d < 0) d = -d;
					if (d < best) begin
						best = d;
						k = i;
					end
				end
			end
			rng = range_tab[k];
			lim = (rng + h < m) ? rng + h : m;
			if (r2 > lim * lim) begin
				updates_due.push_back(u);
				return;
			end
			d = phi - longint'(bearing_tab[k]);
			if (d < 0) d = -d;
			if (2 * d > cone_eff) begin
				updates_due.push_back(u);
				return;
			end
			lo = rng - h;
			if (rng < m && r2 < (rng + h) * (rng + h) && (lo < 0 || r2 > lo * lo)) begin
				u.log_odds = occ_lo;
				u.cell_class = irsm_pkg::CLS_OCCUPIED;
			end else begin
				u.log_odds = free_lo;
				u.cell_class = irsm_pkg::CLS_FREE;
			end
			updates_due.push_back(u);
		endfunction

		function void check_result(logic signed [10:0] lo, logic [1:0] cls);
			cell_update_t u;
			if (updates_due.size() == 0) begin
				$error("unexpected result: log_odds %0d cell_class %0d", lo, cls);
				errors++;
				return;
			end
			u = updates_due.pop_front();
			if (lo !== u.log_odds) begin
				$error("log_odds expected %0d actual %0d", u.log_odds, lo);
				errors++;
			end
			if (cls !== u.cell_class) begin
				$error("cell_class expected %0d actual %0d", u.cell_class, cls);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic op = irsm_pkg::OP_LOAD;
	logic [5:0] beam_index = '0;
	logic [15:0] beam_range = '0;
	logic signed [15:0] beam_bearing = '0;
	logic signed [15:0] point_x = '0;
	logic signed [15:0] point_y = '0;
	logic signed [15:0] robot_x = '0;
	logic signed [15:0] robot_y = '0;
	logic [15:0] robot_heading = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic signed [10:0] log_odds;
	logic [1:0] cell_class;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	odds_board board = new();
	bit no_gaps = 1'b0;

	inverse_range_sensor_model uut (.*);

	always #5 clk = ~clk;

	function automatic int draw_gap();
		if (no_gaps || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 12);
	endfunction

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			board.check_result(log_odds, cell_class);

	// result side: stall a random while, then hold stall low until a transfer
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			n = draw_gap();
			if (n > 0) begin
				out_stall = 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	task automatic send(sensor_item_t it);
		int gap;
		gap = draw_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		op = it.op;
		beam_index = it.beam_index;
		beam_range = it.beam_range;
		beam_bearing = it.beam_bearing;
		point_x = it.point_x;
		point_y = it.point_y;
		robot_x = it.robot_x;
		robot_y = it.robot_y;
		robot_heading = it.robot_heading;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		board.note_input(it);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (board.updates_due.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] data);
		@(negedge clk);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic sensor_item_t load_item(int idx);
		sensor_item_t it;
		it.op = irsm_pkg::OP_LOAD;
		it.beam_index = idx[5:0];
		it.beam_range = ($urandom_range(0, 3) == 0) ? 16'($urandom())
			: 16'($urandom_range(0, int'(board.max_range)));
		it.beam_bearing = 16'($urandom());
		it.point_x = 16'($urandom());
		it.point_y = 16'($urandom());
		it.robot_x = 16'($urandom());
		it.robot_y = 16'($urandom());
		it.robot_heading = 16'($urandom());
		return it;
	endfunction

	// when shaped, point placed within reach of the sensor so the range tests get exercised
	function automatic sensor_item_t query_item(bit shaped);
		sensor_item_t it;
		int reach, px, py;
		it = load_item(0);
		it.op = irsm_pkg::OP_QUERY;
		it.beam_index = 6'($urandom());
		if (shaped) begin
			reach = int'(board.max_range) + int'(board.half_thick) + 10;
			if (reach > 30000) reach = 30000;
			it.robot_x = 16'($urandom_range(0, 4000) - 2000);
			it.robot_y = 16'($urandom_range(0, 4000) - 2000);
			px = int'(it.robot_x) + $urandom_range(0, 2 * reach) - reach;
			py = int'(it.robot_y) + $urandom_range(0, 2 * reach) - reach;
			it.point_x = 16'(px);
			it.point_y = 16'(py);
		end
		return it;
	endfunction

	task automatic set_all(logic [15:0] mr, logic [15:0] ht, logic [15:0] fv,
			logic [6:0] nb, logic [15:0] cn, logic [10:0] fl, logic [10:0] ol,
			logic [10:0] ul);
		write_reg(irsm_pkg::REG_MAX_RANGE, mr);
		write_reg(irsm_pkg::REG_HALF_THICK, ht);
		write_reg(irsm_pkg::REG_FOV, fv);
		write_reg(irsm_pkg::REG_BEAM_COUNT, {9'd0, nb});
		write_reg(irsm_pkg::REG_CONE, cn);
		write_reg(irsm_pkg::REG_FREE_LO, {5'd0, fl});
		write_reg(irsm_pkg::REG_OCC_LO, {5'd0, ol});
		write_reg(irsm_pkg::REG_UNK_LO, {5'd0, ul});
	endtask

	initial begin
		sensor_item_t it;
		int coords [8][4];
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every beam entry is written before any query can read it
		for (int i = 0; i < 64; i++) send(load_item(i));
		// coincident point under reset settings
		it = query_item(1'b0);
		it.point_x = 16'sd100; it.robot_x = 16'sd100;
		it.point_y = -16'sd5; it.robot_y = -16'sd5;
		send(it);
		drain();

		set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd64, 16'd0,
			11'h400, 11'h3FF, 11'h400);
		coords = '{'{32767, 0, -32768, 0}, '{-32768, 0, 32767, 0},
			'{0, 32767, 0, -32768}, '{0, -32768, 0, 32767},
			'{32767, 32767, -32768, -32768}, '{-32768, 32767, 32767, -32768},
			'{0, 0, 0, 0}, '{-1, 1, 0, 0}};
		for (int i = 0; i < 8; i++) begin
			it = query_item(1'b0);
			it.point_x = 16'(coords[i][0]);
			it.point_y = 16'(coords[i][1]);
			it.robot_x = 16'(coords[i][2]);
			it.robot_y = 16'(coords[i][3]);
			it.robot_heading = (i < 4) ? 16'h0000 : 16'hFFFF;
			send(it);
		end
		drain();
		// zero field of view, laser, phi zero and off axis
		set_all(16'd3000, 16'd0, 16'd0, 7'd0, 16'd0, 11'd5, 11'd7, 11'd9);
		for (int i = 0; i < 6; i++) begin
			it = query_item(1'b0);
			it.robot_x = 0; it.robot_y = 0; it.robot_heading = 0;
			it.point_x = 16'(500 * i); it.point_y = (i > 3) ? 16'sd400 : 16'sd0;
			send(it);
		end
		drain();

		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: set_all(16'd5000, 16'd600, 16'd32768, 7'd64, 16'd0,
					11'h7E6, 11'd102, 11'd0);
				1: set_all(16'd8000, 16'd400, 16'd0, 7'd1, 16'd0,
					11'd0, 11'd1, 11'd2);
				2: set_all(16'd6000, 16'd800, 16'd2000, 7'd16, 16'd4000,
					11'h7FF, 11'd300, 11'h500);
				3: set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd127, 16'hFFFF,
					11'h3FF, 11'h400, 11'h3FF);
				4: set_all(16'd0, 16'd0, 16'd100, 7'd0, 16'd200,
					11'd1, 11'd2, 11'd3);
				5: set_all(16'd4000, 16'd1000, 16'd10000, 7'd65, 16'd300,
					11'd50, 11'h600, 11'd0);
				default: set_all(16'($urandom_range(500, 20000)),
					16'($urandom_range(0, 2000)), 16'($urandom()),
					7'($urandom_range(0, 127)),
					$urandom_range(0, 1) ? 16'd0 : 16'($urandom()),
					11'($urandom()), 11'($urandom()), 11'($urandom()));
			endcase
			no_gaps = (ph == 2);
			for (int i = 0; i < 75; i++) begin
				case ($urandom_range(0, 9))
					0, 1: send(load_item($urandom_range(0, 63)));
					2: send(query_item(1'b0));
					default: send(query_item(1'b1));
				endcase
			end
			drain();
		end

		if (board.errors == 0 && board.updates_due.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
